/* design/asd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the snap detector controller and datapath.
// ----------------------------------------------------------------------------
package asd_pkg;

  // input function codes
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_INC    = 2'd2;
  localparam logic [1:0] FUNC_ADJ    = 2'd3;

  // counting modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_SPLIT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_COOLDOWN = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;
  localparam logic [1:0] REG_TOL      = 2'd3;

  localparam logic [15:0] RST_COOLDOWN  = 16'd300;
  localparam logic [15:0] RST_GAP       = 16'd800;
  localparam logic [10:0] RST_TOL       = 11'd300;
  localparam logic [13:0] RST_THRESHOLD = 14'd400;
  localparam logic [13:0] RST_SHARPNESS = 14'd200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_DECIDE,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the item and update window
    logic scan_step; // examine one window entry
    logic div_start; // start the divider
    logic decide;    // apply the decision
    logic fin_start; // start the end-of-calibration arithmetic
    logic present;   // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic div_busy;
    logic need_snap;
    logic need_finish;
  } status_t;

endpackage

/* design/asd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial = {rem, quotient[W-1]} - {1'b0, dsr};

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(W);
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[W]) begin
        rem      <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem      <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* design/asd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_ctrl
// Sequencer: load, window scan, direction divide, decision, end-of-calibration arithmetic, output.
// ----------------------------------------------------------------------------
module asd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  asd_pkg::status_t sts,
  output asd_pkg::cmd_t    cmd
);
  import asd_pkg::*;

  state_t state, state_next;
  logic   out_full;
  logic   wait_div;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (sts.scan_last) state_next = ST_DIVIDE;
      ST_DIVIDE: state_next = ST_DECIDE;
      ST_DECIDE: if (!sts.div_busy && !wait_div) begin
        state_next = sts.need_finish ? ST_FINISH : ST_OUT;
      end
      ST_FINISH: if (!sts.div_busy && !wait_div) state_next = ST_OUT;
      ST_OUT:    if (!out_full || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DIVIDE: cmd.div_start = 1'b1;
      ST_DECIDE: if (!sts.div_busy && !wait_div) begin
        cmd.decide    = 1'b1;
        cmd.fin_start = sts.need_finish;
      end
      ST_OUT:    cmd.present = !out_full || out_ready;
      default:   ;
    endcase
  end

  // wait_div, registered from div_start or fin_start, holds DECIDE and FINISH until busy is seen
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
      wait_div <= 1'b0;
    end else begin
      state    <= state_next;
      wait_div <= cmd.div_start || cmd.fin_start;
      if (cmd.present) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready) else $error("accepted while busy");
  a_present_free: assert property (@(posedge clk) disable iff (rst)
    cmd.present |-> (!out_full || out_ready)) else $error("output overwrite");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE) else $error("load outside idle");
endmodule

/* design/asd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_dp
// Datapath: smoothing, window store, serial peak scan, calibration and
// counters, output register.
// ----------------------------------------------------------------------------
module asd_dp #(
  parameter int WINDOW_LEN     = 12,
  parameter int CALIB_SNAPS    = 10,
  parameter int SETTLE_SAMPLES = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  asd_pkg::cmd_t       cmd,
  output asd_pkg::status_t    sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          func,
  input  logic signed [12:0]  accel_x,
  input  logic signed [12:0]  accel_y,
  input  logic signed [12:0]  accel_z,
  input  logic [31:0]         stamp_ms,
  output logic                snap_counted,
  output logic                pulse,
  output logic [15:0]         first_count,
  output logic [15:0]         second_count,
  output logic                in_calibration,
  output logic                is_calibrated,
  output logic [3:0]          snaps_taken,
  output logic [13:0]         current_threshold
);
  import asd_pkg::*;

  localparam int PW = $clog2(WINDOW_LEN);
  localparam int SW = $clog2(SETTLE_SAMPLES + 1);
  localparam int NW = $clog2(CALIB_SNAPS + 1);
  localparam int DW = 24;

  // reciprocal multipliers for the constant divides, exact below 2^18 and 2^20
  localparam int SN_SH  = 18 + $clog2(CALIB_SNAPS);
  localparam int SN_MUL = (1 << SN_SH) / CALIB_SNAPS + 1;
  localparam int F5_SH  = 23;
  localparam int F5_MUL = (1 << F5_SH) / 5 + 1;

  // configuration
  logic [1:0]  counting_mode;
  logic [15:0] cooldown_len, record_gap;
  logic [10:0] direction_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      counting_mode       <= MODE_OFF;
      cooldown_len        <= RST_COOLDOWN;
      record_gap          <= RST_GAP;
      direction_tolerance <= RST_TOL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     counting_mode       <= cfg_data[1:0];
        REG_COOLDOWN: cooldown_len        <= cfg_data;
        REG_GAP:      record_gap          <= cfg_data;
        REG_TOL:      direction_tolerance <= cfg_data[10:0];
        default:      ;
      endcase
    end
  end

  // state
  logic [13:0]        smoothed_level;
  logic signed [14:0] window_store [WINDOW_LEN];
  logic [PW-1:0]      write_position;
  logic [SW-1:0]      settle_count;
  logic [NW-1:0]      snaps_recorded;
  logic [17:0]        energy_sum;
  logic signed [14:0] direction_sum;
  logic [13:0]        peak_threshold, edge_sharpness;
  logic signed [10:0] mean_direction;
  logic [31:0]        last_count_time, last_record_time;
  logic               calib_running, calib_done;
  logic [15:0]        count_one, count_two;

  // captured item
  logic [1:0]         f_q;
  logic signed [12:0] z_q;
  logic [14:0]        mag_q;
  logic [31:0]        now_q;

  logic [14:0] mag_in;
  logic [17:0] smooth_sum;
  logic [13:0] smooth_new;
  logic [12:0] ax, ay, az;

  assign ax = accel_x[12] ? 13'(-accel_x) : accel_x;
  assign ay = accel_y[12] ? 13'(-accel_y) : accel_y;
  assign az = accel_z[12] ? 13'(-accel_z) : accel_z;
  assign mag_in     = 15'(ax) + 15'(ay) + 15'(az);
  assign smooth_sum = 18'(smoothed_level) * 18'd7 + 18'(mag_in);
  assign smooth_new = smooth_sum[16:3];

  // serial scan over the window, oldest first
  logic [PW-1:0]      scan_p;
  logic [PW-1:0]      scan_idx;
  logic signed [14:0] peak;
  logic signed [14:0] prev_val, peak_prev;
  logic               peak_found, peak_is_first, after_peak, fall_ok;
  logic signed [14:0] cur;

  always_comb begin
    logic [PW:0] s;
    s = {1'b0, write_position} + {1'b0, scan_p};
    if (s >= (PW+1)'(WINDOW_LEN)) s = s - (PW+1)'(WINDOW_LEN);
    scan_idx = s[PW-1:0];
  end
  assign cur = window_store[scan_idx];
  assign sts.scan_last = (scan_p == PW'(WINDOW_LEN - 1));

  logic signed [15:0] half_sharp;
  assign half_sharp = 16'(edge_sharpness >> 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_p     <= '0;
      peak       <= '0;
      peak_found <= 1'b0;
      after_peak <= 1'b0;
      fall_ok    <= 1'b1;
    end else if (cmd.scan_step) begin
      scan_p   <= scan_p + 1'b1;
      prev_val <= cur;
      if (cur > peak) begin
        peak          <= cur;
        peak_found    <= 1'b1;
        peak_is_first <= (scan_p == '0);
        peak_prev     <= prev_val;
        after_peak    <= 1'b1;
        fall_ok       <= 1'b1;
      end else if (after_peak) begin
        after_peak <= 1'b0;
        fall_ok    <= (16'(peak) - 16'(cur)) >= half_sharp;
      end
    end
  end

  logic snap;
  logic signed [15:0] rise;
  assign rise = 16'(peak) - 16'(peak_prev);
  assign snap = peak_found && (16'(peak) >= 16'(peak_threshold)) &&
                (peak_is_first || rise >= 16'(edge_sharpness)) && fall_ok;

  // phase decode
  logic settling, recording, gap_ok, cool_ok;
  assign settling  = calib_running && settle_count < SW'(SETTLE_SAMPLES);
  assign recording = calib_running && !settling &&
                     snaps_recorded < NW'(CALIB_SNAPS);
  assign gap_ok    = (now_q - last_record_time) >= 32'(record_gap);
  assign cool_ok   = (now_q - last_count_time) > 32'(cooldown_len);

  // direction divider
  logic          dv_start, dv_busy;
  logic [DW-1:0] dv_a, dv_b, dv_q;
  logic          fin_phase;
  logic          fin_step;

  asd_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start),
    .dividend(dv_a), .divisor(dv_b), .busy(dv_busy), .quotient(dv_q)
  );
  assign sts.div_busy = dv_busy || fin_phase;

  logic [12:0] z_abs;
  assign z_abs = z_q[12] ? 13'(-z_q) : z_q;

  logic [17:0] avg_r;
  logic [14:0] dsum_abs;
  assign dsum_abs = direction_sum[14] ? 15'(-direction_sum) : direction_sum;

  // divider operands: |z| * 1000 over the magnitude
  assign dv_start = cmd.div_start;
  assign dv_a     = DW'(z_abs) * DW'(1000);
  assign dv_b     = (mag_q == '0) ? DW'(1) : DW'(mag_q);

  // end-of-calibration quotients
  logic [47:0] avg_prod, mean_prod, thr_prod, sharp_prod;
  logic [19:0] avg3;
  logic [10:0] mean_q;
  assign avg_prod   = 48'(energy_sum) * 48'(SN_MUL);
  assign mean_prod  = 48'(dsum_abs) * 48'(SN_MUL);
  assign mean_q     = mean_prod[SN_SH +: 11];
  assign avg3       = 20'(avg_r) * 20'd3;
  assign thr_prod   = 48'(avg3) * 48'(F5_MUL);
  assign sharp_prod = 48'(avg_r) * 48'(F5_MUL);

  logic signed [11:0] dir;
  assign dir = (mag_q == '0) ? 12'sd0 :
               (z_q[12] ? -$signed({1'b0, dv_q[10:0]}) : $signed({1'b0, dv_q[10:0]}));

  logic signed [12:0] ddiff;
  logic [12:0]        ddiff_abs;
  assign ddiff     = 13'(dir) - 13'(mean_direction);
  assign ddiff_abs = ddiff[12] ? 13'(-ddiff) : ddiff;

  logic [17:0] energy_sum_next_w;
  logic        rec_hit;
  assign rec_hit = f_q == FUNC_SAMPLE && recording && gap_ok && snap;
  assign energy_sum_next_w = energy_sum + 18'(peak);
  assign sts.need_snap   = 1'b0;
  assign sts.need_finish = rec_hit && (snaps_recorded == NW'(CALIB_SNAPS - 1));

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 1'b1;
  endfunction

  logic counted_r, pulse_r;

  // item processing
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_level   <= '0;
      write_position   <= '0;
      settle_count     <= '0;
      snaps_recorded   <= '0;
      energy_sum       <= '0;
      direction_sum    <= '0;
      peak_threshold   <= RST_THRESHOLD;
      edge_sharpness   <= RST_SHARPNESS;
      mean_direction   <= '0;
      last_count_time  <= '0;
      last_record_time <= '0;
      calib_running    <= 1'b0;
      calib_done       <= 1'b0;
      count_one        <= '0;
      count_two        <= '0;
      fin_phase        <= 1'b0;
      fin_step         <= 1'b0;
      counted_r        <= 1'b0;
      pulse_r          <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) window_store[i] <= '0;
    end else begin
      if (cmd.load) begin
        f_q       <= func;
        z_q       <= accel_z;
        mag_q     <= mag_in;
        now_q     <= stamp_ms;
        counted_r <= 1'b0;
        pulse_r   <= 1'b0;
        if (func == FUNC_SAMPLE) begin
          smoothed_level <= smooth_new;
          window_store[write_position] <= 15'(mag_in) - 15'(smooth_new);
          write_position <= (write_position == PW'(WINDOW_LEN - 1)) ? '0 :
                            write_position + 1'b1;
        end
      end
      if (cmd.decide) begin
        case (f_q)
          FUNC_SAMPLE: begin
            if (settling) begin
              settle_count <= settle_count + 1'b1;
            end else if (recording) begin
              if (rec_hit) begin
                energy_sum       <= energy_sum_next_w;
                direction_sum    <= direction_sum + 15'(dir);
                snaps_recorded   <= snaps_recorded + 1'b1;
                last_record_time <= now_q;
                pulse_r          <= 1'b1;
              end
            end else if (calib_done && !calib_running && cool_ok && snap &&
                         ddiff_abs < 13'(direction_tolerance)) begin
              if (counting_mode == MODE_SINGLE) begin
                count_one <= sat_inc(count_one);
              end else if (counting_mode == MODE_SPLIT) begin
                if (dir > 12'(mean_direction)) count_one <= sat_inc(count_one);
                else count_two <= sat_inc(count_two);
              end
              last_count_time <= now_q;
              counted_r <= 1'b1;
              pulse_r   <= 1'b1;
            end
          end
          FUNC_START: begin
            calib_running    <= 1'b1;
            calib_done       <= 1'b0;
            settle_count     <= '0;
            snaps_recorded   <= '0;
            energy_sum       <= '0;
            direction_sum    <= '0;
            last_record_time <= '0;
          end
          FUNC_INC: begin
            if (counting_mode == MODE_SINGLE || counting_mode == MODE_SPLIT)
              count_one <= sat_inc(count_one);
          end
          FUNC_ADJ: begin
            if (counting_mode == MODE_SINGLE) begin
              if (count_one != '0) count_one <= count_one - 1'b1;
            end else if (counting_mode == MODE_SPLIT) begin
              count_two <= sat_inc(count_two);
            end
          end
          default: ;
        endcase
      end
      // end of calibration: average and mean direction, then threshold and sharpness
      if (cmd.fin_start) begin
        fin_phase <= 1'b1;
        fin_step  <= 1'b0;
      end else if (fin_phase && !fin_step) begin
        avg_r          <= avg_prod[SN_SH +: 18];
        mean_direction <= direction_sum[14] ? 11'(-mean_q) : mean_q;
        fin_step       <= 1'b1;
      end else if (fin_phase) begin
        peak_threshold <= thr_prod[F5_SH +: 14];
        edge_sharpness <= sharp_prod[F5_SH +: 14];
        calib_done     <= 1'b1;
        calib_running  <= 1'b0;
        fin_phase      <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_counted      <= 1'b0;
      pulse             <= 1'b0;
      first_count       <= '0;
      second_count      <= '0;
      in_calibration    <= 1'b0;
      is_calibrated     <= 1'b0;
      snaps_taken       <= '0;
      current_threshold <= RST_THRESHOLD;
    end else if (cmd.present) begin
      snap_counted      <= counted_r;
      pulse             <= pulse_r;
      first_count       <= count_one;
      second_count      <= count_two;
      in_calibration    <= calib_running;
      is_calibrated     <= calib_done;
      snaps_taken       <= 4'(snaps_recorded);
      current_threshold <= peak_threshold;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (count_one == 16'hFFFF && !(cmd.decide && f_q == FUNC_ADJ)) |=> count_one == 16'hFFFF)
    else $error("counter wrapped");
  a_snaps_max: assert property (@(posedge clk) disable iff (rst)
    snaps_recorded <= NW'(CALIB_SNAPS)) else $error("too many snaps");
  a_counted_pulse: assert property (@(posedge clk) disable iff (rst)
    counted_r |-> pulse_r) else $error("count without pulse");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.present |=> $stable(first_count)) else $error("output moved");
endmodule

/* design/accel_snap_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_snap_detector_core
// Accelerometer snap detector with self-calibration and snap counters.
// ----------------------------------------------------------------------------
// channel   handshake             payload
// in        in_valid / in_ready   func, accel_x/y/z, stamp_ms
// out       out_valid / out_ready snap_counted .. current_threshold
// cfg       cfg_we                cfg_index, cfg_data
//
// One item in flight: a load, the serial window scan, a divider start,
// the direction divide and a decision, then an output.
// The last calibration snap adds the end-of-calibration arithmetic.
// Reset (rst, synchronous) restores the configuration, calibration,
// counter and output register defaults.
// A held output register lets the next item start while a result waits.
// ----------------------------------------------------------------------------
module accel_snap_detector_core #(
  parameter int WINDOW_LEN     = 12,
  parameter int CALIB_SNAPS    = 10,
  parameter int SETTLE_SAMPLES = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [12:0] accel_x,
  input  logic signed [12:0] accel_y,
  input  logic signed [12:0] accel_z,
  input  logic [31:0]        stamp_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               snap_counted,
  output logic               pulse,
  output logic [15:0]        first_count,
  output logic [15:0]        second_count,
  output logic               in_calibration,
  output logic               is_calibrated,
  output logic [3:0]         snaps_taken,
  output logic [13:0]        current_threshold
);
  import asd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  asd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  asd_dp #(
    .WINDOW_LEN(WINDOW_LEN), .CALIB_SNAPS(CALIB_SNAPS),
    .SETTLE_SAMPLES(SETTLE_SAMPLES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .stamp_ms(stamp_ms),
    .snap_counted(snap_counted), .pulse(pulse), .first_count(first_count),
    .second_count(second_count), .in_calibration(in_calibration),
    .is_calibrated(is_calibrated), .snaps_taken(snaps_taken),
    .current_threshold(current_threshold)
  );
endmodule
